// File: hdl/binomial_mod_prime_macros.svh
// ----------------------------------------------------------------------------
// binomial_mod_prime_macros
// Assertion macros shared by the binomial block.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_MOD_PRIME_MACROS_SVH
`define BINOMIAL_MOD_PRIME_MACROS_SVH

// Check that cond implies nxt in the following cycle, outside reset.
`define BMP_ASSERT_NEXT(label, clk, rst, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error("bmp check failed");

// Check that cond implies res in the same cycle, outside reset.
`define BMP_ASSERT_NOW(label, clk, rst, cond, res) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (res)) \
    else $error("bmp check failed");

`endif

// File: hdl/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Constants and types shared by the binomial coefficient block.
// ----------------------------------------------------------------------------
package bmp_pkg;
  localparam logic [29:0] PRIME = 30'd998244353;
  localparam logic [29:0] FERMAT_EXP = 30'd998244351;
  localparam int unsigned FIELD_W = 12;
  localparam int unsigned COEFF_W = 30;

  // Barrett reciprocal floor(2^60 / p) and 2p for the final correction.
  localparam logic [30:0] BARRETT_M = 31'((64'd1 << 60) / 64'(PRIME));
  localparam logic [31:0] PRIME_X2 = 32'(PRIME) << 1;

  // Classified query passed from the front end to the back end.
  typedef struct packed {
    logic [FIELD_W-1:0] n;
    logic [FIELD_W-1:0] r;
    logic               bad;
    logic               trivial;
  } bmp_cmd_t;

  typedef struct packed {
    logic                start;
    logic [COEFF_W-1:0]  a;
    logic [COEFF_W-1:0]  b;
  } bmp_mul_req_t;
endpackage

// File: hdl/binomial_mod_prime.sv
// ----------------------------------------------------------------------------
// binomial_mod_prime
// C(n, r) mod 998244353 from a factorial table and Fermat inverses.
// ----------------------------------------------------------------------------
// channel  | signals               | handshake
// query    | start, n, r           | taken when start && !busy
// result   | done, coeff, range_error | one-cycle strobe on done
//
// After reset the table fill runs TABLE_DEPTH-1 products; busy stays high
// until it ends. An in-range query with r > 0 takes two 30-bit
// square-and-multiply runs of 58 products each, all on the one pipelined
// modular multiplier. Out-of-range and r == 0 queries bypass the
// multiplier and go straight to the done pulse. Up to two queries wait in
// the queue, busy is high while it is full; the result side cannot stall.
module binomial_mod_prime #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] n,
  input  logic [11:0] r,
  output logic        done,
  output logic [29:0] coeff,
  output logic        range_error
);
  import bmp_pkg::*;

  logic     q_valid;
  logic     q_pop;
  logic     ready;
  bmp_cmd_t q_head;

  bmp_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .start(start), .ready_in(ready), .n(n), .r(r),
    .busy(busy), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  bmp_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .ready(ready), .done(done), .coeff(coeff), .range_error(range_error)
  );
endmodule

// File: hdl/bmp_modmul.sv
// ----------------------------------------------------------------------------
// bmp_modmul
// Pipelined modular multiplier: 30x30 product, then Barrett reduction mod p
// with a fixed reciprocal through the qest, qp and rem registers. Done pulses
// as the result is registered; the product holds until the next start.
// ----------------------------------------------------------------------------
module bmp_modmul (
  input  logic                      clk,
  input  logic                      rst,
  input  bmp_pkg::bmp_mul_req_t     req,
  output logic                      done,
  output logic [bmp_pkg::COEFF_W-1:0] prod
);
  import bmp_pkg::*;

  logic [59:0] full;
  logic [29:0] qest;
  logic [31:0] qp;
  logic [31:0] rem;
  logic [29:0] res;
  logic [1:0]  stage;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      stage <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        stage <= 2'd0;
      end else if (busy) begin
        stage <= stage + 2'd1;
        if (stage == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient estimate from the top product bits is low by at most two,
  // so the remainder needs at most two subtractions of p.
  always_ff @(posedge clk) begin
    if (req.start && !busy) full <= 60'(req.a) * 60'(req.b);
    qest <= 30'((62'(full[59:29]) * 62'(BARRETT_M)) >> 31);
    qp   <= 32'(60'(qest) * 60'(PRIME));
    rem  <= full[31:0] - qp;
    res  <= (rem >= PRIME_X2) ? 30'(rem - PRIME_X2) :
            (rem >= 32'(PRIME)) ? 30'(rem - 32'(PRIME)) : rem[29:0];
  end

  assign prod = res;
endmodule

// File: hdl/bmp_front.sv
// ----------------------------------------------------------------------------
// bmp_front
// Accepts queries, classifies them and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
module bmp_front #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      ready_in,
  input  logic [bmp_pkg::FIELD_W-1:0] n,
  input  logic [bmp_pkg::FIELD_W-1:0] r,
  output logic                      busy,
  output logic                      q_valid,
  output bmp_pkg::bmp_cmd_t         q_head,
  input  logic                      q_pop
);
  import bmp_pkg::*;

  bmp_cmd_t   slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  bmp_cmd_t   cmd;

  assign busy  = !ready_in || (count == 2'd2);
  assign push  = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_head  = slot[rd_ptr];

  always_comb begin
    cmd.n       = n;
    cmd.r       = r;
    cmd.bad     = (32'(n) >= TABLE_DEPTH) || (r > n);
    cmd.trivial = (r == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= cmd;
  end
endmodule

// File: hdl/bmp_back.sv
// ----------------------------------------------------------------------------
// bmp_back
// Fills the factorial table after reset, then executes queries: two Fermat
// inverses by square-and-multiply and two final products on one multiplier.
// ----------------------------------------------------------------------------
module bmp_back #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  bmp_pkg::bmp_cmd_t           q_head,
  output logic                        q_pop,
  output logic                        ready,
  output logic                        done,
  output logic [bmp_pkg::COEFF_W-1:0] coeff,
  output logic                        range_error
);
  import bmp_pkg::*;
  `include "binomial_mod_prime_macros.svh"

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  typedef enum logic [9:0] {
    S_FILL   = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_RD     = 10'b0000000100,
    S_RDW    = 10'b0000001000,
    S_POW    = 10'b0000010000,
    S_POWW   = 10'b0000100000,
    S_NEXT   = 10'b0001000000,
    S_FIN1   = 10'b0010000000,
    S_FIN2   = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } st_t;

  st_t st;
  logic [COEFF_W-1:0] mem [TABLE_DEPTH];
  logic [COEFF_W-1:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic [AW:0]        fill_idx;
  logic [COEFF_W-1:0] fill_val;
  logic               fill_wait;
  bmp_cmd_t           cmd;
  logic [1:0]         phase;     // 0: read fac[n], 1: fac[r], 2: fac[n-r]
  logic [COEFF_W-1:0] fac_n;
  logic [COEFF_W-1:0] inv_r;
  logic [COEFF_W-1:0] acc;
  logic [COEFF_W-1:0] sq;
  logic [4:0]         bit_idx;
  logic               sq_turn;
  bmp_mul_req_t       mreq;
  logic               mdone;
  logic [COEFF_W-1:0] mprod;

  bmp_modmul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .prod(mprod));

  assign ready = (st != S_FILL);
  assign q_pop = (st == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (st == S_FILL && !fill_wait && fill_idx < (AW+1)'(TABLE_DEPTH))
      mem[fill_idx[AW-1:0]] <= fill_val;
  end

  always_comb begin
    unique case (phase)
      2'd0:    rd_addr = AW'(cmd.n);
      2'd1:    rd_addr = AW'(cmd.r);
      default: rd_addr = AW'(cmd.n - cmd.r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_FILL;
      fill_idx  <= '0;
      fill_val  <= 30'd1;
      fill_wait <= 1'b0;
      mreq      <= '0;
      done      <= 1'b0;
      phase     <= '0;
    end else begin
      mreq.start <= 1'b0;
      done       <= 1'b0;
      unique case (st)
        S_FILL: begin
          // Write entry, then multiply by the next index.
          if (!fill_wait) begin
            if (fill_idx == (AW+1)'(TABLE_DEPTH - 1)) begin
              st <= S_IDLE;
            end else begin
              mreq <= '{start: 1'b1, a: fill_val, b: COEFF_W'(fill_idx + 1'b1)};
              fill_wait <= 1'b1;
            end
          end else if (mdone) begin
            fill_val  <= mprod;
            fill_idx  <= fill_idx + 1'b1;
            fill_wait <= 1'b0;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd   <= q_head;
            phase <= 2'd0;
            if (q_head.bad || q_head.trivial) begin
              coeff       <= q_head.bad ? '0 : 30'd1;
              range_error <= q_head.bad;
              st          <= S_OUT;
            end else begin
              st <= S_RD;
            end
          end
        end
        S_RD: st <= S_RDW;
        S_RDW: begin
          if (phase == 2'd0) begin
            fac_n <= rd_data;
            phase <= 2'd1;
            st    <= S_RD;
          end else begin
            sq      <= rd_data;
            acc     <= 30'd1;
            bit_idx <= '0;
            sq_turn <= 1'b0;
            st      <= S_POW;
          end
        end
        S_POW: begin
          // Multiply when the exponent bit is set, then square.
          if (!sq_turn && !FERMAT_EXP[bit_idx]) begin
            sq_turn <= 1'b1;
          end else begin
            mreq <= '{start: 1'b1, a: (sq_turn ? sq : acc), b: sq};
            st <= S_POWW;
          end
        end
        S_POWW: begin
          if (mdone) begin
            if (sq_turn) begin
              sq      <= mprod;
              sq_turn <= 1'b0;
              if (bit_idx == 5'd29) st <= S_NEXT;
              else begin
                bit_idx <= bit_idx + 5'd1;
                st      <= S_POW;
              end
            end else begin
              acc     <= mprod;
              sq_turn <= 1'b1;
              st      <= S_POW;
            end
          end
        end
        S_NEXT: begin
          if (phase == 2'd1) begin
            inv_r <= acc;
            phase <= 2'd2;
            st    <= S_RD;
          end else begin
            mreq <= '{start: 1'b1, a: fac_n, b: inv_r};
            st   <= S_FIN1;
          end
        end
        S_FIN1: begin
          if (mdone) begin
            mreq <= '{start: 1'b1, a: mprod, b: acc};
            st   <= S_FIN2;
          end
        end
        S_FIN2: begin
          if (mdone) begin
            coeff       <= mprod;
            range_error <= 1'b0;
            st          <= S_OUT;
          end
        end
        S_OUT: begin
          done <= 1'b1;
          st   <= S_IDLE;
        end
        default: st <= S_FILL;
      endcase
    end
  end

  `BMP_ASSERT_NEXT(a_pop_leaves_idle, clk, rst, q_pop, st != S_IDLE)
  `BMP_ASSERT_NOW(a_err_zero, clk, rst, done && range_error, coeff == '0)
  `BMP_ASSERT_NOW(a_no_done_fill, clk, rst, st == S_FILL, !done)
endmodule
